// File: hw/rtl/wss_pkg.sv
// Package for the wave string stencil step core.
// Holds sizes, operation codes, word types and the cell control struct.
// No dependencies.
`default_nettype none

package wss_pkg;

    localparam int POINTS   = 64;
    localparam int IDX_W    = 6;
    localparam int DISP_W   = 24;
    localparam int K_W      = 16;
    localparam int OP_W     = 2;

    localparam logic [K_W-1:0] K_RESET = 16'd26542;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [IDX_W-1:0]         point_index;
        logic signed [DISP_W-1:0] write_value;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]         read_index;
        logic signed [DISP_W-1:0] read_value;
    } out_word_t;

    typedef struct packed {
        logic step;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/wave_string_stencil_step_core.sv
// Wave string stencil step core: a row of POINTS cells, one per string point.
// A step updates all cells at once, each cell with its own multiply; a read is
// answered through the output register, parked in the skid stage on a stall.
// Sustained rate is one word per cycle while the output side keeps up.
// Reset clears both displacement stores to zero and sets k to 0.81 (unsigned Q1.15).
`default_nettype none

module wave_string_stencil_step_core
    import wss_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input words
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire in_word_t       in_data,
    // result words
    output logic                out_valid,
    input  wire logic           out_stall,
    output out_word_t           out_data,
    // courant_squared register
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [K_W-1:0] cfg_data
);

    // -------------------------------------------------------------------
    // Configuration: the squared Courant number, always writable
    // -------------------------------------------------------------------
    logic [K_W-1:0] k_reg, k_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        k_next = k_reg;
        if (cfg_valid && cfg_ready)
            k_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= K_RESET;
        else
            k_reg <= k_next;
    end

    // -------------------------------------------------------------------
    // Input decode
    // -------------------------------------------------------------------
    logic in_take;
    logic do_write;
    logic do_step;
    logic do_read;
    logic idx_ok;

    // hold off only while both the output register and the skid stage are full
    logic skid_valid_reg, skid_valid_next;
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;

    assign idx_ok   = 32'(in_data.point_index) < POINTS;
    assign do_write = in_take && (in_data.operation == OP_WRITE) && idx_ok;
    assign do_step  = in_take && (in_data.operation == OP_STEP);
    assign do_read  = in_take && (in_data.operation == OP_READ);

    // -------------------------------------------------------------------
    // Cell row: each cell sees its neighbors' current displacement
    // -------------------------------------------------------------------
    logic signed [DISP_W-1:0] cur_bus [POINTS];
    logic signed [DISP_W-1:0] rd_value;

    for (genvar i = 0; i < POINTS; i++)
    begin : g_cell
        cell_ctrl_t               ctrl;
        logic signed [DISP_W-1:0] left_cur;
        logic signed [DISP_W-1:0] right_cur;

        assign ctrl.step = do_step;
        assign ctrl.load = do_write && (32'(in_data.point_index) == i);

        // end cells ignore their neighbor inputs: they are forced to zero on a step
        if (i == 0)
        begin : g_left_end
            assign left_cur = '0;
        end
        else
        begin : g_left
            assign left_cur = cur_bus[i-1];
        end

        if (i == POINTS - 1)
        begin : g_right_end
            assign right_cur = '0;
        end
        else
        begin : g_right
            assign right_cur = cur_bus[i+1];
        end

        wss_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .end_point  ((i == 0) || (i == POINTS - 1)),
            .k          (k_reg),
            .load_value (in_data.write_value),
            .left_cur   (left_cur),
            .right_cur  (right_cur),
            .cur        (cur_bus[i])
        );
    end

    // read select: an index past the last point reads as zero
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < POINTS; i++)
        begin
            if (32'(in_data.point_index) == i)
                rd_value = cur_bus[i];
        end
    end

    // -------------------------------------------------------------------
    // Output register with one skid stage behind it
    // -------------------------------------------------------------------
    out_word_t rd_word;
    out_word_t out_word_reg, out_word_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign rd_word.read_index = in_data.point_index;
    assign rd_word.read_value = rd_value;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (out_free)
        begin
            // drain the skid stage first; no read is taken while it is full
            out_valid_next  = skid_valid_reg || do_read;
            out_word_next   = skid_valid_reg ? skid_word_reg : rd_word;
            skid_valid_next = 1'b0;
        end
        else if (do_read)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = rd_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_read_parks_in_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (do_read && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("read result lost behind a stalled output");

    a_left_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        do_step |=> (cur_bus[0] == '0))
        else $error("left end point not forced to zero by a step");

    a_right_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        do_step |=> (cur_bus[POINTS-1] == '0))
        else $error("right end point not forced to zero by a step");

endmodule

`default_nettype wire

// File: hw/rtl/wss_cell.sv
// One string point: current and previous displacement plus its leapfrog update.
// Depends on wss_pkg.
`default_nettype none

module wss_cell
    import wss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic                     end_point,
    input  wire logic [K_W-1:0]           k,
    input  wire logic signed [DISP_W-1:0] load_value,
    input  wire logic signed [DISP_W-1:0] left_cur,
    input  wire logic signed [DISP_W-1:0] right_cur,
    output logic signed [DISP_W-1:0]      cur
);

    localparam int LAP_W  = DISP_W + 3;
    localparam int PROD_W = LAP_W + K_W + 1;
    localparam int TERM_W = PROD_W - 15;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(8388608);

    logic signed [DISP_W-1:0] cur_reg, cur_next;
    logic signed [DISP_W-1:0] prev_reg, prev_next;

    logic signed [LAP_W-1:0]  lap;
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DISP_W-1:0] upd;

    always_comb
    begin
        lap  = LAP_W'(right_cur) + LAP_W'(left_cur) - (LAP_W'(cur_reg) <<< 1);
        prod = PROD_W'(lap) * $signed({1'b0, k}) + PROD_W'(16384);
        // arithmetic shift floors toward minus infinity
        term = TERM_W'(prod >>> 15);
        sum  = (SUM_W'(cur_reg) <<< 1) - SUM_W'(prev_reg) + SUM_W'(term);
        if (sum > SAT_MAX)
            upd = DISP_W'(SAT_MAX);
        else if (sum < SAT_MIN)
            upd = DISP_W'(SAT_MIN);
        else
            upd = DISP_W'(sum);
    end

    always_comb
    begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        if (ctrl.step)
        begin
            prev_next = cur_reg;
            cur_next  = end_point ? '0 : upd;
        end
        else if (ctrl.load)
        begin
            cur_next  = load_value;
            prev_next = load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
        end
    end

    assign cur = cur_reg;

endmodule

`default_nettype wire
